// ===== rtl/core/hfd_pkg.sv =====
// Shared types and constants for the heartbeat failure detector.
// Holds the payload words, the peer entry layout, the control/status structs and codes.
// No dependencies.
package hfd_pkg;

   // Peer table geometry; the peer field width sets the depth.
   localparam int PEER_W = 4;
   localparam int PEERS = 1 << PEER_W;

   // Restoring divider: the quotient always fits in 16 bits.
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 4'd1;
   localparam logic [7:0] THRESHOLD_RESET = 8'd3;
   localparam logic [7:0] LIMIT_RESET = 8'd5;

   // Event kinds carried in the request word.
   typedef enum logic [2:0] {
      KIND_SENT  = 3'd0,
      KIND_RECV  = 3'd1,
      KIND_TMO   = 3'd2,
      KIND_STALE = 3'd3,
      KIND_CLEAR = 3'd4
   } kind_type;

   // Event results reported in the response word.
   typedef enum logic [1:0] {
      EV_NONE      = 2'd0,
      EV_SUSPECTED = 2'd1,
      EV_RECOVERED = 2'd2
   } ev_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [PEER_W-1:0] peer;
      logic [15:0]       latency_ms;
   } req_type;

   typedef struct packed {
      logic [PEER_W-1:0] peer_out;
      logic [1:0]        event_res;
      logic [15:0]       failure_run;
      logic              suspected;
      logic              healthy;
      logic [31:0]       sent_count;
      logic [31:0]       received_count;
      logic [15:0]       mean_latency;
      logic [15:0]       lat_min;
      logic [15:0]       lat_max;
   } rsp_type;

   // One peer's statistics.
   typedef struct packed {
      logic [31:0] sent;
      logic [31:0] recv;
      logic [15:0] fail;
      logic        sus;
      logic [15:0] mean;
      logic [15:0] low;
      logic [15:0] high;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{
      sent: 32'd0, recv: 32'd0, fail: 16'd0, sus: 1'b0,
      mean: 16'd0, low: 16'hFFFF, high: 16'd0
   };

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul;
      logic div_start;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_div;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

// ===== rtl/core/hfd_div.sv =====
// Restoring divider for the running mean, one quotient bit per cycle.
// Depends on hfd_pkg for the step count.
module hfd_div
   import hfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [47:0] dividend,
   input  logic [32:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [33:0]          rem_ff;
   logic [33:0]          rem_in;
   logic [15:0]          low_ff;
   logic [32:0]          dsr_ff;
   logic [15:0]          quo_ff;
   logic [33:0]          rem_shift;
   logic                 fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      rem_shift = {rem_ff[32:0], low_ff[15]};
      fits = rem_shift >= {1'b0, dsr_ff};
      rem_in = fits ? (rem_shift - {1'b0, dsr_ff}) : rem_shift;
   end

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Partial remainder and quotient. The upper dividend half is below the
   // divisor because the quotient fits in 16 bits.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {2'b00, dividend[47:16]};
         low_ff <= dividend[15:0];
         dsr_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[14:0], 1'b0};
         quo_ff <= {quo_ff[14:0], fits};
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

   a_start_clears_done: assert property (@(posedge clock) disable iff (reset)
      start |=> !done_ff)
      else $error("divider reports done right after a start");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !start) |=> done_ff)
      else $error("divider done dropped without a new start");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done at once");

endmodule

// ===== rtl/core/hfd_dp.sv =====
// Datapath: peer table, configuration registers, mean multiplier and divider,
// entry update logic and the response register. Depends on hfd_pkg and hfd_div.
module hfd_dp
   import hfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   entry_type         table_ff [PEERS];
   entry_type         ent_ff;
   entry_type         ent_new;
   logic [2:0]        kind_ff;
   logic [PEER_W-1:0] peer_ff;
   logic [15:0]       lat_ff;
   logic [47:0]       prod_ff;
   logic [7:0]        thresh_ff;
   logic [7:0]        limit_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   ev_type            ev;
   logic              div_done;
   logic [15:0]       quotient;
   logic [15:0]       fail_inc;
   logic [15:0]       fail_inc2;
   logic              trip1;
   logic              trip2;
   logic              sus1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESHOLD_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: thresh_ff <= csr_wdata;
            CSR_LIMIT:     limit_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Capture the event and read its entry when it is accepted.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_data.kind;
         peer_ff <= req_data.peer;
         lat_ff <= req_data.latency_ms;
         ent_ff <= table_ff[req_data.peer];
      end
   end

   // Numerator of the running mean: mean times old count plus latency.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= (48'(ent_ff.mean) * 48'(ent_ff.recv)) + 48'(lat_ff);
      end
   end

   hfd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  ({1'b0, ent_ff.recv} + 33'd1),
      .done     (div_done),
      .quotient (quotient)
   );

   // New entry value and event result.
   always_comb begin
      ent_new = ent_ff;
      ev = EV_NONE;
      fail_inc = (ent_ff.fail == 16'hFFFF) ? ent_ff.fail : ent_ff.fail + 16'd1;
      fail_inc2 = fail_inc;
      trip1 = 1'b0;
      trip2 = 1'b0;
      sus1 = ent_ff.sus;
      case (kind_ff)
         KIND_SENT: begin
            if (ent_ff.sent != 32'hFFFF_FFFF) begin
               ent_new.sent = ent_ff.sent + 32'd1;
            end
         end
         KIND_RECV: begin
            if (ent_ff.recv != 32'hFFFF_FFFF) begin
               ent_new.recv = ent_ff.recv + 32'd1;
            end
            ent_new.fail = '0;
            if (lat_ff < ent_ff.low) begin
               ent_new.low = lat_ff;
            end
            if (lat_ff > ent_ff.high) begin
               ent_new.high = lat_ff;
            end
            ent_new.mean = (ent_ff.recv == 32'd0) ? lat_ff : quotient;
            if (ent_ff.sus) begin
               ent_new.sus = 1'b0;
               ev = EV_RECOVERED;
            end
         end
         KIND_TMO: begin
            ent_new.fail = fail_inc;
            if (fail_inc >= {8'd0, thresh_ff} && !ent_ff.sus) begin
               ent_new.sus = 1'b1;
               ev = EV_SUSPECTED;
            end
         end
         KIND_STALE: begin
            // Test before the increment, then again after it if it happens.
            trip1 = (ent_ff.fail >= {8'd0, thresh_ff}) && !ent_ff.sus;
            sus1 = ent_ff.sus || trip1;
            if (ent_ff.fail < {8'd0, limit_ff}) begin
               ent_new.fail = fail_inc2;
               trip2 = (fail_inc2 >= {8'd0, thresh_ff}) && !sus1;
            end
            ent_new.sus = sus1 || trip2;
            if (trip1 || trip2) begin
               ev = EV_SUSPECTED;
            end
         end
         KIND_CLEAR: begin
            ent_new = ENTRY_RESET;
         end
         default: ;
      endcase
   end

   // Peer table, written back at commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PEERS; i++) begin
            table_ff[i] <= ENTRY_RESET;
         end
      end else if (cmd.commit) begin
         table_ff[peer_ff] <= ent_new;
      end
   end

   // Response register; it frees itself when the word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.peer_out <= peer_ff;
         rsp_ff.event_res <= ev;
         rsp_ff.failure_run <= ent_new.fail;
         rsp_ff.suspected <= ent_new.sus;
         rsp_ff.healthy <= !ent_new.sus && (ent_new.fail < {8'd0, limit_ff});
         rsp_ff.sent_count <= ent_new.sent;
         rsp_ff.received_count <= ent_new.recv;
         rsp_ff.mean_latency <= ent_new.mean;
         rsp_ff.lat_min <= ent_new.low;
         rsp_ff.lat_max <= ent_new.high;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign status.need_div = (kind_ff == KIND_RECV) && (ent_ff.recv != 32'd0);
   assign status.div_done = div_done;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   a_commit_after_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status.need_div) |-> div_done)
      else $error("mean committed before the division finished");

endmodule

// ===== rtl/core/hfd_ctrl.sv =====
// Controller state machine: sequences load, multiply, divide and commit.
// Depends on hfd_pkg for the state, command and status types.
module hfd_ctrl
   import hfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.need_div ? ST_MUL : ST_COMMIT;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.rsp_free)
      else $error("response committed over an untaken word");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall)
      else $error("new word taken while one is in work");

   a_commit_then_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !req_stall)
      else $error("controller not idle after commit");

endmodule

// ===== rtl/core/heartbeat_failure_detector.sv =====
// Heartbeat failure detector top level: joins the controller and the datapath.
// Depends on hfd_pkg, hfd_ctrl and hfd_dp.
//
// Usage: each request word names a peer (16 entries) and an event kind:
// probe sent, response with latency, timeout, stale peer or clear entry.
// Every request yields one response word describing that peer's entry after
// the update, with an event code for a new suspicion or a recovery.
// Requests are taken on req_valid with req_stall low; responses leave on
// rsp_valid and are taken when rsp_stall is low. Registers are written on
// the csr channel (index 0 suspicion threshold, 1 failure limit), which is
// always ready; write them only while no request is in work.
// Sequencing: one request is in work at a time; the next request is taken
// only once the last one is committed. Most events go from the check state
// straight to commit. A response event on a peer with earlier responses also
// passes the 48-bit multiply-add and the 16-step restoring divider for the
// running mean. A finished response waits in the output register while the
// next request is taken; a held rsp_stall delays only the following commit.
// Reset clears the peer table (the low field, which tracks the minimum, to 65535)
// and restores the threshold to 3 and the limit to 5.
module heartbeat_failure_detector
   import hfd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Configuration writes are taken in any cycle.
   assign csr_ready = 1'b1;

   hfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hfd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
